### rtl/core/protected_bitset_with_change_marks_defines.svh
// Assertion macros for the protected bit set with change marks.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef PROTECTED_BITSET_WITH_CHANGE_MARKS_DEFINES_SVH
`define PROTECTED_BITSET_WITH_CHANGE_MARKS_DEFINES_SVH

`ifndef SYNTHESIS
// clocked property, disabled while reset is asserted
`define PBCM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed in %m");
// clocked property, checked during reset as well
`define PBCM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed in %m");
`else
`define PBCM_ASSERT(lbl, clk, rstn, prop)
`define PBCM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/pbcm_pkg.sv
// Package for the protected bit set with change marks: command codes,
// word types passed between stages and default constants. No dependencies.
package pbcm_pkg;

  // default number of elements and count after reset
  localparam int unsigned SizeDefault = 64;
  localparam logic [6:0]  CountReset  = 7'd32;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_SET_STATE = 3'd1,
    CMD_SET_PROT  = 3'd2,
    CMD_CLR_CHG   = 3'd3,
    CMD_CLR_GRP   = 3'd4,
    CMD_SET_ALL   = 3'd5,
    CMD_RST_PROT  = 3'd6,
    CMD_CLR_ALL   = 3'd7
  } pbcm_cmd_e;

  // one command word as held in the input register
  typedef struct packed {
    pbcm_cmd_e  cmd;
    logic [7:0] index;
    logic       value;
    logic       force_req;
    logic [5:0] group;
    logic       wide_group;
  } pbcm_item_t;

  // one result word
  typedef struct packed {
    logic       flipped;
    logic       state_bit;
    logic       change_bit;
    logic       protect_bit;
    logic [7:0] group_states;
    logic [7:0] group_changes;
    logic       pending;
  } pbcm_result_t;

endpackage

### rtl/core/pbcm_in_stage.sv
// Input register of the bit set: holds one command word with its valid flag.
// Depends on pbcm_pkg.
module pbcm_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pbcm_pkg::pbcm_item_t item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output pbcm_pkg::pbcm_item_t item_o
);
  import pbcm_pkg::*;

  logic       valid_q, valid_d;
  pbcm_item_t item_q;
  logic       accept;

  // free when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/pbcm_update.sv
// Single-pass update of the three bit vectors and result word computation.
// Depends on pbcm_pkg.
module pbcm_update #(
  parameter int unsigned SIZE = pbcm_pkg::SizeDefault
) (
  input  pbcm_pkg::pbcm_item_t          item_i,
  input  logic [6:0]                    active_count_i,
  input  logic [((SIZE+7)/8)*8-1:0]     state_i,
  input  logic [((SIZE+7)/8)*8-1:0]     change_i,
  input  logic [((SIZE+7)/8)*8-1:0]     protect_i,
  output logic [((SIZE+7)/8)*8-1:0]     state_o,
  output logic [((SIZE+7)/8)*8-1:0]     change_o,
  output logic [((SIZE+7)/8)*8-1:0]     protect_o,
  output pbcm_pkg::pbcm_result_t        result_o
);
  import pbcm_pkg::*;

  localparam int unsigned NBytes = (SIZE + 7) / 8;
  localparam int unsigned W      = NBytes * 8;
  localparam int unsigned IdxW   = $clog2(W);

  logic [6:0]   cnt;
  logic [3:0]   nb;
  logic         in_range;
  logic [W-1:0] bitsel;
  logic [W-1:0] span;
  logic [W-1:0] gmask;
  logic [W-1:0] lvl;
  logic [5:0]   bsel;
  logic         gvalid;
  logic [7:0]   nib_mask;
  logic [W-1:0] st_grp, ch_grp;
  logic [7:0]   st_byte, ch_byte;
  logic         cur;
  logic         flipped;

  // effective count, span in bytes, element and group selection
  always_comb begin
    cnt      = (active_count_i > 7'(SIZE)) ? 7'(SIZE) : active_count_i;
    nb       = 4'(({1'b0, cnt} + 8'd7) >> 3);
    in_range = item_i.index < {1'b0, cnt};
    bitsel   = in_range ? (W'(1) << item_i.index[IdxW-1:0]) : '0;
    bsel     = item_i.wide_group ? item_i.group : {1'b0, item_i.group[5:1]};
    gvalid   = bsel < {2'b00, nb};
    nib_mask = item_i.wide_group ? 8'hff : (item_i.group[0] ? 8'hf0 : 8'h0f);
    for (int b = 0; b < NBytes; b++) begin
      span[b*8 +: 8]  = (4'(b) < nb) ? 8'hff : 8'h00;
      gmask[b*8 +: 8] = (gvalid && (bsel == 6'(b))) ? nib_mask : 8'h00;
    end
  end

  // next vector values
  always_comb begin
    state_o   = state_i;
    change_o  = change_i;
    protect_o = protect_i;
    flipped   = 1'b0;
    cur       = |(state_i & bitsel);
    lvl       = item_i.value ? span : '0;
    unique case (item_i.cmd)
      CMD_READ: begin
      end
      CMD_SET_STATE: begin
        if (in_range && (item_i.force_req || !(|(protect_i & bitsel)))
            && (cur != item_i.value)) begin
          state_o  = state_i ^ bitsel;
          change_o = change_i | bitsel;
          flipped  = 1'b1;
        end
      end
      CMD_SET_PROT: begin
        protect_o = item_i.value ? (protect_i | bitsel) : (protect_i & ~bitsel);
      end
      CMD_CLR_CHG: begin
        change_o = change_i & ~bitsel;
      end
      CMD_CLR_GRP: begin
        change_o = change_i & ~gmask;
      end
      CMD_SET_ALL: begin
        change_o = (change_i & ~span) | ((state_i ^ lvl) & span);
        state_o  = (state_i & ~span) | lvl;
      end
      CMD_RST_PROT: begin
        protect_o = protect_i & ~span;
      end
      CMD_CLR_ALL: begin
        change_o = change_i & ~span;
      end
    endcase
  end

  // group readout: at most one byte survives the mask
  always_comb begin
    st_grp  = state_o & gmask;
    ch_grp  = change_o & gmask;
    st_byte = 8'h00;
    ch_byte = 8'h00;
    for (int b = 0; b < NBytes; b++) begin
      st_byte = st_byte | st_grp[b*8 +: 8];
      ch_byte = ch_byte | ch_grp[b*8 +: 8];
    end
  end

  // result word
  always_comb begin
    result_o.flipped     = flipped;
    result_o.state_bit   = |(state_o & bitsel);
    result_o.change_bit  = |(change_o & bitsel);
    result_o.protect_bit = |(protect_o & bitsel);
    if (item_i.wide_group) begin
      result_o.group_states  = st_byte;
      result_o.group_changes = ch_byte;
    end else if (item_i.group[0]) begin
      result_o.group_states  = st_byte >> 4;
      result_o.group_changes = ch_byte >> 4;
    end else begin
      result_o.group_states  = st_byte & 8'h0f;
      result_o.group_changes = ch_byte & 8'h0f;
    end
    result_o.pending = |(change_o & span);
  end

endmodule

### rtl/core/protected_bitset_with_change_marks.sv
// A command word accepted into the input register passes through the update
// pass to the result register. Throughput: one word per cycle while the result
// register is free or being drained, set by the single update pass between them.
// Reset: state, change and protection vectors clear to zero, the element
// count returns to 32, both registers empty.
`include "protected_bitset_with_change_marks_defines.svh"

module protected_bitset_with_change_marks #(
  parameter int unsigned SIZE = pbcm_pkg::SizeDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  // command words
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] index_i,
  input  logic       value_i,
  input  logic       force_req_i,
  input  logic [5:0] group_i,
  input  logic       wide_group_i,
  // result words
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       flipped_o,
  output logic       state_bit_o,
  output logic       change_bit_o,
  output logic       protect_bit_o,
  output logic [7:0] group_states_o,
  output logic [7:0] group_changes_o,
  output logic       pending_o
);
  import pbcm_pkg::*;

  localparam int unsigned W = ((SIZE + 7) / 8) * 8;

  pbcm_item_t   in_item, held_item;
  logic         held_valid;
  logic         advance;
  logic [6:0]   count_q;
  logic [W-1:0] state_q, change_q, protect_q;
  logic [W-1:0] state_d, change_d, protect_d;
  pbcm_result_t res_d, res_q;
  logic         out_valid_q, out_valid_d;

  // configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // input register
  always_comb begin
    in_item.cmd        = pbcm_cmd_e'(cmd_i);
    in_item.index      = index_i;
    in_item.value      = value_i;
    in_item.force_req  = force_req_i;
    in_item.group      = group_i;
    in_item.wide_group = wide_group_i;
  end

  pbcm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // word moves on when the result register is free or being drained
  assign advance = held_valid && (!out_valid_q || out_ready_i);

  pbcm_update #(
    .SIZE (SIZE)
  ) u_update (
    .item_i         (held_item),
    .active_count_i (count_q),
    .state_i        (state_q),
    .change_i       (change_q),
    .protect_i      (protect_q),
    .state_o        (state_d),
    .change_o       (change_d),
    .protect_o      (protect_d),
    .result_o       (res_d)
  );

  // bit vectors commit together with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      change_q  <= '0;
      protect_q <= '0;
    end else if (advance) begin
      state_q   <= state_d;
      change_q  <= change_d;
      protect_q <= protect_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign flipped_o       = res_q.flipped;
  assign state_bit_o     = res_q.state_bit;
  assign change_bit_o    = res_q.change_bit;
  assign protect_bit_o   = res_q.protect_bit;
  assign group_states_o  = res_q.group_states;
  assign group_changes_o = res_q.group_changes;
  assign pending_o       = res_q.pending;

  // vectors only move when a word is processed
  `PBCM_ASSERT(a_vec_hold, clk_i, rst_ni,
    !advance |=> ($stable(state_q) && $stable(change_q) && $stable(protect_q)))
  // change marks are raised only by set state or set all
  `PBCM_ASSERT(a_chg_source, clk_i, rst_ni,
    (advance && (held_item.cmd != CMD_SET_STATE) && (held_item.cmd != CMD_SET_ALL))
      |=> ((change_q & ~$past(change_q)) == '0))
  // a reported flip really toggled one state bit
  `PBCM_ASSERT(a_flip_real, clk_i, rst_ni,
    (advance && res_d.flipped) |=> ($countones(state_q ^ $past(state_q)) == 1))
  // protection is never altered by state commands
  `PBCM_ASSERT(a_prot_source, clk_i, rst_ni,
    (advance && (held_item.cmd == CMD_SET_STATE)) |=> $stable(protect_q))
  // result register is empty while reset is asserted
  `PBCM_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_q)

endmodule
